### hdl/plmcs_pkg.sv
// shared constants and codes for the piecewise luma map and chroma scale block
package plmcs_pkg;

    // bin count and default fractional precisions
    localparam int BIN_COUNT        = 16;
    localparam int NUM_BINS         = BIN_COUNT;
    localparam int FP_PREC          = 11;
    localparam int CHROMA_PREC      = 11;

    // field widths
    localparam int OP_W    = 3;
    localparam int BIN_W   = 4;
    localparam int DELTA_W = 10;
    localparam int SAMP_W  = 12;
    localparam int RES_W   = 20;
    localparam int CW_W    = 10;
    localparam int PIV_W   = 15;
    localparam int FWD_W   = 18;
    localparam int INV_W   = 20;
    localparam int CS_W    = 20;
    localparam int CFG_W   = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 3'd1;
    localparam logic [OP_W-1:0] OP_FWD   = 3'd2;
    localparam logic [OP_W-1:0] OP_INV   = 3'd3;
    localparam logic [OP_W-1:0] OP_CS    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [1:0] REG_MIN_BIN   = 2'd1;
    localparam logic [1:0] REG_MAX_BIN   = 2'd2;
    localparam logic [1:0] REG_CH_OFFSET = 2'd3;

    // packed coefficient word as stored in memory
    typedef struct packed {
        logic [CS_W-1:0]  cs;
        logic [INV_W-1:0] inv;
        logic [FWD_W-1:0] fwd;
    } coef_t;

endpackage

### hdl/plmcs_ram.sv
// generic single-port synchronous ram with registered read
module plmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read data registered, old contents returned on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### hdl/piecewise_luma_map_chroma_scale_top.sv
// Luma mapping with chroma scaling over 16 bins. One item is handled at a time:
// a delta write or an unknown operation goes through the lookup and result
// states, a forward or inverse map through lookup, multiply, add and result,
// and a chroma scale through lookup, multiply and result; the coefficient
// memory read and the multiply are registered. A build walks the 16 bins, each
// bin reading its delta, then running two restoring divisions on one shared
// divider and writing the coefficient word. Configuration writes are always
// accepted and belong to times when no item is in flight.
module piecewise_luma_map_chroma_scale_top
    import plmcs_pkg::*;
#(
    parameter int FRAC_BITS        = FP_PREC,
    parameter int CHROMA_FRAC_BITS = CHROMA_PREC
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beat: operation, bin_index, codeword_delta, sample, zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // result beat: operation_done, result_value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int MAXF  = (FRAC_BITS > CHROMA_FRAC_BITS) ? FRAC_BITS : CHROMA_FRAC_BITS;
    localparam int DW    = 9 + MAXF;
    localparam int DCW   = $clog2(DW + 1);
    localparam int DVS_W = 11;
    localparam int PRD_W = 38;
    localparam int T_W   = 39;
    localparam int FW_W  = CW_W + FRAC_BITS + 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOOK = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_ADD  = 4'd3;
    localparam logic [3:0] ST_RES  = 4'd4;
    localparam logic [3:0] ST_BRD  = 4'd5;
    localparam logic [3:0] ST_BCW  = 4'd6;
    localparam logic [3:0] ST_BDIV = 4'd7;
    localparam logic [3:0] ST_BWR  = 4'd8;

    logic [3:0]         state_reg;
    logic [CFG_W-1:0]   bit_depth_reg, min_bin_reg, max_bin_reg, ch_off_reg;
    logic [OP_W-1:0]    op_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [SAMP_W-1:0]  samp_reg;
    logic [NUM_BINS-1:0] dvalid_reg;
    logic               built_reg;
    logic [PIV_W-1:0]   piv_reg [NUM_BINS+1];
    logic [4:0]         cnt_reg;
    logic [PIV_W-1:0]   acc_reg;
    logic [CW_W-1:0]    cw_reg;
    logic [FWD_W-1:0]   fwd_reg;
    logic [DVS_W-1:0]   cdiv_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DW-1:0]      quo_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic               dsel_reg;
    logic [INV_W-1:0]   invq_reg;
    logic signed [16:0] d_reg;
    logic [PIV_W-1:0]   base_reg;
    logic signed [PRD_W-1:0] prod_reg;
    logic [RES_W-1:0]   res_reg;
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;

    // config and derived depth values
    logic [3:0]         dep, lg;
    logic [SAMP_W-1:0]  maxv, s_clip;
    always_comb
    begin
        if (bit_depth_reg < 4'd8)
        begin
            dep = 4'd8;
        end
        else if (bit_depth_reg > 4'd12)
        begin
            dep = 4'd12;
        end
        else
        begin
            dep = bit_depth_reg;
        end
        lg     = dep - 4'd4;
        maxv   = SAMP_W'((13'(1) << dep) - 13'(1));
        s_clip = (samp_reg > maxv) ? maxv : samp_reg;
    end

    // pivot search over the configured bin range
    logic [NUM_BINS-1:0] hit;
    logic [BIN_W-1:0]    found;
    always_comb
    begin
        found = BIN_W'(NUM_BINS - 1);
        for (int i = 0; i < NUM_BINS; i++)
        begin
            hit[i] = (BIN_W'(i) >= min_bin_reg) && (BIN_W'(i) <= max_bin_reg)
                     && ({3'b0, s_clip} < piv_reg[i+1]);
        end
        for (int i = NUM_BINS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found = BIN_W'(i);
            end
        end
    end

    // lookup index, distance and base for map items
    logic [BIN_W-1:0]   idx_look;
    logic signed [16:0] d_look;
    logic [PIV_W-1:0]   base_look;
    always_comb
    begin
        if (op_reg == OP_FWD)
        begin
            idx_look  = BIN_W'(s_clip >> lg);
            d_look    = $signed({5'b0, s_clip & SAMP_W'((13'(1) << lg) - 13'(1))});
            base_look = piv_reg[idx_look];
        end
        else
        begin
            idx_look  = found;
            d_look    = $signed({5'b0, s_clip}) - $signed({2'b0, piv_reg[found]});
            base_look = PIV_W'({11'b0, found} << lg);
        end
    end

    // delta memory
    logic               d_we;
    logic [BIN_W-1:0]   d_addr;
    logic [DELTA_W-1:0] d_rdata;
    assign d_we   = (state_reg == ST_LOOK) && (op_reg == OP_WRITE);
    assign d_addr = (state_reg == ST_LOOK) ? bin_reg : cnt_reg[BIN_W-1:0];

    plmcs_ram #(.WIDTH(DELTA_W), .DEPTH(NUM_BINS)) u_delta_ram (
        .clk   (clk),
        .we    (d_we),
        .addr  (d_addr),
        .wdata (delta_reg),
        .rdata (d_rdata)
    );

    // coefficient memory
    logic       c_we;
    logic [BIN_W-1:0] c_addr;
    coef_t      c_wdata, c_rdata, coef;
    assign c_we   = (state_reg == ST_BWR);
    assign c_addr = (state_reg == ST_BWR) ? cnt_reg[BIN_W-1:0] : idx_look;

    plmcs_ram #(.WIDTH($bits(coef_t)), .DEPTH(NUM_BINS)) u_coef_ram (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

    // coefficients read as their reset value until the first build
    always_comb
    begin
        if (built_reg)
        begin
            coef = c_rdata;
        end
        else
        begin
            coef.fwd = FWD_W'(2048);
            coef.inv = INV_W'(2048);
            coef.cs  = CS_W'(2048);
        end
    end

    // bin codeword and forward coefficient of the bin being built
    logic signed [11:0]  cw_v;
    logic [CW_W-1:0]     cw_c;
    logic [FW_W-1:0]     fwd_raw;
    logic [FWD_W-1:0]    fwd_c;
    logic signed [11:0]  div_v;
    logic [DVS_W-1:0]    div_c;
    logic [DELTA_W-1:0]  delta_rd;
    always_comb
    begin
        delta_rd = dvalid_reg[cnt_reg[BIN_W-1:0]] ? d_rdata : '0;
        cw_v = $signed({{2{delta_rd[DELTA_W-1]}}, delta_rd})
               + $signed(12'(12'd1 << lg));
        if ((cnt_reg[BIN_W-1:0] < min_bin_reg) || (cnt_reg[BIN_W-1:0] > max_bin_reg)
            || (cw_v < 0))
        begin
            cw_c = '0;
        end
        else if (cw_v > 12'sd1023)
        begin
            cw_c = CW_W'(1023);
        end
        else
        begin
            cw_c = cw_v[CW_W-1:0];
        end
        fwd_raw = ((FW_W'(cw_c) << FRAC_BITS) + (FW_W'(1) << (lg - 4'd1))) >> lg;
        fwd_c   = (fwd_raw > FW_W'({FWD_W{1'b1}})) ? {FWD_W{1'b1}} : fwd_raw[FWD_W-1:0];
        div_v   = $signed({2'b0, cw_c}) + $signed({{8{ch_off_reg[3]}}, ch_off_reg});
        div_c   = (div_v <= 0) ? DVS_W'(1) : div_v[DVS_W-1:0];
    end

    // one restoring division step
    logic [DVS_W:0]   rem_sh;
    logic             q_bit;
    logic [DVS_W-1:0] divisor;
    logic [DVS_W-1:0] rem_step;
    logic [INV_W-1:0] q_sat;
    always_comb
    begin
        divisor  = dsel_reg ? cdiv_reg : ((cw_reg == '0) ? DVS_W'(1) : DVS_W'(cw_reg));
        rem_sh   = {rem_reg, quo_reg[DW-1]};
        q_bit    = rem_sh >= {1'b0, divisor};
        rem_step = q_bit ? DVS_W'(rem_sh - {1'b0, divisor}) : rem_sh[DVS_W-1:0];
        q_sat    = (quo_reg > DW'({INV_W{1'b1}})) ? {INV_W{1'b1}} : INV_W'(quo_reg);
    end

    // coefficient word written at the end of a bin
    always_comb
    begin
        c_wdata.fwd = fwd_reg;
        if (cw_reg == '0)
        begin
            c_wdata.inv = '0;
            c_wdata.cs  = CS_W'(1) << CHROMA_FRAC_BITS;
        end
        else
        begin
            c_wdata.inv = invq_reg;
            c_wdata.cs  = q_sat;
        end
    end

    // rounding, floor shift, base add and clip of a map result
    logic signed [T_W-1:0] t_sum, t_sh, v_sum;
    logic [RES_W-1:0]      map_res;
    always_comb
    begin
        t_sum = T_W'(prod_reg) + (T_W'(1) <<< (FRAC_BITS - 1));
        t_sh  = t_sum >>> FRAC_BITS;
        v_sum = t_sh + $signed(T_W'(base_reg));
        if (v_sum < 0)
        begin
            map_res = '0;
        end
        else if (v_sum > $signed(T_W'(maxv)))
        begin
            map_res = RES_W'(maxv);
        end
        else
        begin
            map_res = RES_W'(v_sum);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= 4'd10;
            min_bin_reg   <= 4'd0;
            max_bin_reg   <= 4'd15;
            ch_off_reg    <= 4'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BIT_DEPTH: bit_depth_reg <= cfg_data;
                REG_MIN_BIN:   min_bin_reg   <= cfg_data;
                REG_MAX_BIN:   max_bin_reg   <= cfg_data;
                REG_CH_OFFSET: ch_off_reg    <= cfg_data;
                default:       ch_off_reg    <= ch_off_reg;
            endcase
        end
    end

    // item payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= s_axis_tdata[2:0];
            bin_reg   <= s_axis_tdata[6:3];
            delta_reg <= s_axis_tdata[16:7];
            samp_reg  <= s_axis_tdata[28:17];
        end
        if (state_reg == ST_LOOK)
        begin
            d_reg    <= d_look;
            base_reg <= base_look;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= $signed({1'b0, (op_reg == OP_FWD) ? INV_W'(coef.fwd) : coef.inv})
                        * d_reg;
        end
        if (state_reg == ST_BCW)
        begin
            cw_reg   <= cw_c;
            fwd_reg  <= fwd_c;
            cdiv_reg <= div_c;
        end
    end

    // control: item sequencer, build walk and shared divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dvalid_reg    <= '0;
            built_reg     <= 1'b0;
            for (int i = 0; i <= NUM_BINS; i++)
            begin
                piv_reg[i] <= '0;
            end
            cnt_reg       <= '0;
            acc_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            dcnt_reg      <= '0;
            dsel_reg      <= 1'b0;
            invq_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // result beat taken; the result state reloads the register itself
            if (out_valid_reg && m_axis_tready && (state_reg != ST_RES))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    res_reg <= '0;
                    if (op_reg == OP_WRITE)
                    begin
                        dvalid_reg[bin_reg] <= 1'b1;
                        state_reg <= ST_RES;
                    end
                    else if (op_reg == OP_BUILD)
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_BRD;
                    end
                    else if (op_reg == OP_FWD || op_reg == OP_INV || op_reg == OP_CS)
                    begin
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_RES;
                    end
                end
                ST_MUL:
                begin
                    if (op_reg == OP_CS)
                    begin
                        res_reg   <= coef.cs;
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    res_reg   <= map_res;
                    state_reg <= ST_RES;
                end
                ST_RES:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, res_reg, op_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_BRD:
                begin
                    state_reg <= ST_BCW;
                end
                ST_BCW:
                begin
                    acc_reg <= acc_reg + PIV_W'(cw_c);
                    piv_reg[cnt_reg + 5'd1] <= acc_reg + PIV_W'(cw_c);
                    rem_reg   <= '0;
                    quo_reg   <= DW'(1) << (FRAC_BITS + 32'(lg));
                    dcnt_reg  <= '0;
                    dsel_reg  <= 1'b0;
                    state_reg <= ST_BDIV;
                end
                ST_BDIV:
                begin
                    if (dcnt_reg == DCW'(DW))
                    begin
                        if (!dsel_reg)
                        begin
                            invq_reg <= q_sat;
                            rem_reg  <= '0;
                            quo_reg  <= DW'(1) << (CHROMA_FRAC_BITS + 32'(lg));
                            dcnt_reg <= '0;
                            dsel_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_BWR;
                        end
                    end
                    else
                    begin
                        rem_reg  <= rem_step;
                        quo_reg  <= {quo_reg[DW-2:0], q_bit};
                        dcnt_reg <= dcnt_reg + DCW'(1);
                    end
                end
                ST_BWR:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(NUM_BINS - 1))
                    begin
                        built_reg <= 1'b1;
                        state_reg <= ST_RES;
                    end
                    else
                    begin
                        state_reg <= ST_BRD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the sequencer takes no beat while an item is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");

    // the divider never runs past its dividend width
    assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DCW'(DW))
        else $error("divider step count overrun");

    // the last bin written marks the tables as built
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BWR && cnt_reg == 5'(NUM_BINS - 1)) |=> built_reg)
        else $error("build end not recorded");

    // output pivots are a running sum and never decrease
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BCW) |=> (piv_reg[NUM_BINS] >= piv_reg[1]) || (cnt_reg != 5'(NUM_BINS - 1)))
        else $error("pivot sum decreased");

endmodule
